@@ rtl/market_order_fifo_matcher_defines.svh @@
// assertion macros for the market order fifo matcher
// included by rtl files that carry concurrent assertions, no other dependencies
`ifndef MARKET_ORDER_FIFO_MATCHER_DEFINES_SVH
`define MARKET_ORDER_FIFO_MATCHER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MOFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define MOFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mofm_pkg.sv @@
// shared types and constants of the market order fifo matcher
// no dependencies
`default_nettype none

package mofm_pkg;

   localparam int SEC_W   = 3;
   localparam int QTY_W   = 31;
   localparam int IDENT_W = 32;
   localparam int ENTRY_W = IDENT_W + QTY_W;

   typedef enum logic [1:0] {
      EV_RESTING_FILLED  = 2'd0,
      EV_INCOMING_FILLED = 2'd1,
      EV_QUEUED          = 2'd2,
      EV_DROPPED         = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [IDENT_W-1:0]   event_order;
      logic [QTY_W-1:0]     left_quantity;
      logic                 last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/mofm_req_if.sv @@
// order channel: valid/ready handshake with the incoming order fields
// depends on mofm_pkg
`default_nettype none

interface mofm_req_if import mofm_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SEC_W-1:0]   security_index;
   logic               is_buy;
   logic [QTY_W-1:0]   quantity;
   logic [IDENT_W-1:0] order_ident;

   modport source (
      output valid, security_index, is_buy, quantity, order_ident,
      input  ready
   );
   modport sink (
      input  valid, security_index, is_buy, quantity, order_ident,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/mofm_rsp_if.sv @@
// event channel: valid/ready handshake with the match event fields
// depends on mofm_pkg
`default_nettype none

interface mofm_rsp_if import mofm_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         event_kind;
   logic [IDENT_W-1:0] event_order;
   logic [QTY_W-1:0]   left_quantity;
   logic               last;

   modport source (
      output valid, event_kind, event_order, left_quantity, last,
      input  ready
   );
   modport sink (
      input  valid, event_kind, event_order, left_quantity, last,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/market_order_fifo_matcher.sv @@
// top level of the market order fifo matcher: sequencer, entry and pointer memories
// depends on mofm_pkg, mofm_req_if, mofm_rsp_if, mofm_out_stage and the defines header

// One FIFO of resting market orders is kept per security and side, in an entry
// memory (identifier and quantity) and a pointer memory (head and count), both
// synchronous with a registered read. An order takes one item slot and walks
// the opposite side's FIFO from the front, one resting entry at a time (pointer
// read, then an entry-read and compare loop). An order stops when a fill reduces
// a resting order, pops that order too when quantities match exactly, and else
// queues or drops what is left once the FIFO is empty; each event waits out any
// stall on the event side. A zero quantity yields one event. An order with an
// out-of-range security index is taken but yields no event; every other order
// yields events ending with last set. After reset the pointer memory is cleared
// one FIFO at a time, during which no order is taken.
`default_nettype none
`include "market_order_fifo_matcher_defines.svh"

module market_order_fifo_matcher import mofm_pkg::*; #(
   parameter int NUM_SECURITIES = 8,
   parameter int FIFO_DEPTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   mofm_req_if.sink    req,
   mofm_rsp_if.source  rsp
);

   localparam int NUM_FIFOS = NUM_SECURITIES * 2;
   localparam int FW        = $clog2(NUM_FIFOS);
   localparam int HW        = $clog2(FIFO_DEPTH);
   localparam int CW        = $clog2(FIFO_DEPTH + 1);
   localparam int PW        = HW + CW;
   localparam int ENT_NUM   = NUM_FIFOS * FIFO_DEPTH;
   localparam int EAW       = $clog2(ENT_NUM);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_ZERO     = 7'b0000010,
      S_OPP_WAIT = 7'b0000100,
      S_CHECK    = 7'b0001000,
      S_ENT      = 7'b0010000,
      S_POPLAST  = 7'b0100000,
      S_OWN      = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [FW-1:0]      opp_ff, opp_in;
   logic [FW-1:0]      own_ff, own_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [HW-1:0]      hd_ff, hd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               clr_ff, clr_in;
   logic [FW-1:0]      clr_idx_ff, clr_idx_in;

   // memories
   logic [ENTRY_W-1:0] ent_mem [ENT_NUM];
   logic [ENTRY_W-1:0] ent_rdata_ff;
   logic [PW-1:0]      ptr_mem [NUM_FIFOS];
   logic [PW-1:0]      ptr_rdata_ff;

   logic               ent_re, ent_we;
   logic [EAW-1:0]     ent_raddr, ent_waddr;
   logic [ENTRY_W-1:0] ent_wdata;
   logic               ptr_re, ptr_we, fsm_ptr_we;
   logic [FW-1:0]      ptr_raddr, ptr_waddr, fsm_ptr_waddr;
   logic [PW-1:0]      ptr_wdata, fsm_ptr_wdata;

   logic               out_load, out_free;
   rsp_item_type       out_item;

   logic               req_fire, in_range;
   logic [FW-1:0]      req_opp, req_own;
   logic [QTY_W-1:0]   rest_qty;
   logic [IDENT_W-1:0] rest_ident;
   logic [HW-1:0]      hd_next;
   logic [HW-1:0]      own_hd;
   logic [CW-1:0]      own_cnt;
   logic [HW:0]        slot_sum;
   logic [HW-1:0]      own_slot;
   logic [EAW-1:0]     opp_addr, own_addr;

   assign req.ready = (state_ff == S_IDLE) && !clr_ff;
   assign req_fire  = req.valid && req.ready;
   assign in_range  = 32'(req.security_index) < NUM_SECURITIES;
   assign req_opp   = FW'({req.security_index, ~req.is_buy});
   assign req_own   = FW'({req.security_index, req.is_buy});

   assign rest_qty   = ent_rdata_ff[QTY_W-1:0];
   assign rest_ident = ent_rdata_ff[ENTRY_W-1:QTY_W];
   assign hd_next    = (hd_ff == HW'(FIFO_DEPTH - 1)) ? '0 : hd_ff + HW'(1);
   assign own_hd     = ptr_rdata_ff[PW-1:CW];
   assign own_cnt    = ptr_rdata_ff[CW-1:0];
   assign slot_sum   = {1'b0, own_hd} + (HW+1)'(own_cnt);
   assign own_slot   = (slot_sum >= (HW+1)'(FIFO_DEPTH))
                       ? HW'(slot_sum - (HW+1)'(FIFO_DEPTH)) : HW'(slot_sum);
   assign opp_addr   = EAW'(32'(opp_ff) * FIFO_DEPTH + 32'(hd_ff));
   assign own_addr   = EAW'(32'(own_ff) * FIFO_DEPTH + 32'(own_slot));

   always_comb begin
      state_in      = state_ff;
      opp_in        = opp_ff;
      own_in        = own_ff;
      qty_in        = qty_ff;
      ident_in      = ident_ff;
      hd_in         = hd_ff;
      cnt_in        = cnt_ff;
      ent_re        = 1'b0;
      ent_raddr     = opp_addr;
      ent_we        = 1'b0;
      ent_waddr     = opp_addr;
      ent_wdata     = {rest_ident, rest_qty - qty_ff};
      ptr_re        = 1'b0;
      ptr_raddr     = req_opp;
      fsm_ptr_we    = 1'b0;
      fsm_ptr_waddr = opp_ff;
      fsm_ptr_wdata = {hd_ff, cnt_ff};
      out_load      = 1'b0;
      out_item      = '{event_kind: EV_INCOMING_FILLED, event_order: ident_ff,
                        left_quantity: '0, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (req_fire && in_range) begin
               opp_in   = req_opp;
               own_in   = req_own;
               qty_in   = req.quantity;
               ident_in = req.order_ident;
               if (req.quantity == '0) begin
                  state_in = S_ZERO;
               end else begin
                  ptr_re   = 1'b1;
                  state_in = S_OPP_WAIT;
               end
            end
         end
         S_ZERO: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OPP_WAIT: begin
            hd_in    = ptr_rdata_ff[PW-1:CW];
            cnt_in   = ptr_rdata_ff[CW-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cnt_ff == '0) begin
               ptr_re    = 1'b1;
               ptr_raddr = own_ff;
               state_in  = S_OWN;
            end else begin
               ent_re   = 1'b1;
               state_in = S_ENT;
            end
         end
         S_ENT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (rest_qty > qty_ff) begin
                  // resting order reduced, incoming order done
                  ent_we     = 1'b1;
                  fsm_ptr_we = 1'b1;
                  state_in   = S_IDLE;
               end else if (rest_qty == qty_ff) begin
                  out_item.last = 1'b0;
                  state_in      = S_POPLAST;
               end else begin
                  out_item.event_kind  = EV_RESTING_FILLED;
                  out_item.event_order = rest_ident;
                  out_item.last        = 1'b0;
                  qty_in               = qty_ff - rest_qty;
                  hd_in                = hd_next;
                  cnt_in               = cnt_ff - CW'(1);
                  fsm_ptr_we           = 1'b1;
                  fsm_ptr_wdata        = {hd_next, cnt_ff - CW'(1)};
                  state_in             = S_CHECK;
               end
            end
         end
         S_POPLAST: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_item.event_kind  = EV_RESTING_FILLED;
               out_item.event_order = rest_ident;
               fsm_ptr_we           = 1'b1;
               fsm_ptr_wdata        = {hd_next, cnt_ff - CW'(1)};
               state_in             = S_IDLE;
            end
         end
         S_OWN: begin
            if (out_free) begin
               out_load               = 1'b1;
               out_item.left_quantity = qty_ff;
               if (own_cnt < CW'(FIFO_DEPTH)) begin
                  out_item.event_kind = EV_QUEUED;
                  ent_we              = 1'b1;
                  ent_waddr           = own_addr;
                  ent_wdata           = {ident_ff, qty_ff};
                  fsm_ptr_we          = 1'b1;
                  fsm_ptr_waddr       = own_ff;
                  fsm_ptr_wdata       = {own_hd, own_cnt + CW'(1)};
               end else begin
                  out_item.event_kind = EV_DROPPED;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // pointer clear sweep after reset
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + FW'(1);
         if (clr_idx_ff == FW'(NUM_FIFOS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   assign ptr_we    = clr_ff || fsm_ptr_we;
   assign ptr_waddr = clr_ff ? clr_idx_ff : fsm_ptr_waddr;
   assign ptr_wdata = clr_ff ? '0 : fsm_ptr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      opp_ff   <= opp_in;
      own_ff   <= own_in;
      qty_ff   <= qty_in;
      ident_ff <= ident_in;
      hd_ff    <= hd_in;
      cnt_ff   <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rdata_ff <= ent_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_waddr] <= ptr_wdata;
      end
      if (ptr_re) begin
         ptr_rdata_ff <= ptr_mem[ptr_raddr];
      end
   end

   mofm_out_stage u_out_stage (
      .clock (clock),
      .reset (reset),
      .load  (out_load),
      .item  (out_item),
      .free  (out_free),
      .rsp   (rsp)
   );

   `MOFM_ASSERT_NOW(a_no_accept_in_clear, clock, reset, clr_ff, !req.ready, "item taken during clear")
   `MOFM_ASSERT_NOW(a_load_when_free, clock, reset, out_load, out_free, "event register overrun")
   `MOFM_ASSERT_NOW(a_count_in_range, clock, reset, ptr_we, (ptr_wdata[CW-1:0] <= CW'(FIFO_DEPTH)), "fifo count beyond depth")
   `MOFM_ASSERT_NOW(a_ptr_no_overlap, clock, reset, (ptr_re && ptr_we), (ptr_raddr != ptr_waddr), "pointer read and write collide")
   `MOFM_ASSERT_NOW(a_ent_write_state, clock, reset, ent_we, (state_ff == S_ENT || state_ff == S_OWN), "entry write outside update states")
   `MOFM_ASSERT_NEXT(a_last_ends_item, clock, reset, (out_load && out_item.last), (state_ff == S_IDLE), "last event not closing the item")

endmodule

`default_nettype wire

@@ rtl/mofm_out_stage.sv @@
// output register for match events, decouples the matcher from the event sink
// depends on mofm_pkg and mofm_rsp_if
`default_nettype none

module mofm_out_stage import mofm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   output logic         free,
   mofm_rsp_if.source   rsp
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.event_kind    = item_ff.event_kind;
   assign rsp.event_order   = item_ff.event_order;
   assign rsp.left_quantity = item_ff.left_quantity;
   assign rsp.last          = item_ff.last;

endmodule

`default_nettype wire

@@ dv/mofm_match_checker.sv @@
// checker for the market order fifo matcher: watches the order and event channels,
// keeps its own copy of the resting order books and compares every event in order
// depends on mofm_pkg, mofm_req_if and mofm_rsp_if
module mofm_match_checker import mofm_pkg::*; #(
   parameter int NUM_SECURITIES = 8,
   parameter int FIFO_DEPTH     = 16
) (
   input  logic  clock,
   input  logic  reset,
   mofm_req_if   req,
   mofm_rsp_if   rsp,
   output int    fail_count,
   output int    pending_count,
   output int    order_count,
   output int    event_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BOOKS = NUM_SECURITIES * 2;
   localparam int PTR_W     = $clog2(FIFO_DEPTH);

   logic [IDENT_W-1:0] resting_ident [NUM_BOOKS][FIFO_DEPTH];
   logic [QTY_W-1:0]   resting_qty   [NUM_BOOKS][FIFO_DEPTH];
   logic [PTR_W-1:0]   book_head     [NUM_BOOKS];
   logic [PTR_W:0]     book_count    [NUM_BOOKS];
   rsp_item_type       expected_events [$];

   function automatic logic [PTR_W-1:0] wrap_slot(int s);
      return PTR_W'(s % FIFO_DEPTH);
   endfunction

   function automatic void add_event(event_kind_type kind, logic [IDENT_W-1:0] ident,
                                     logic [QTY_W-1:0] left);
      rsp_item_type ev;
      ev.event_kind    = kind;
      ev.event_order   = ident;
      ev.left_quantity = left;
      ev.last          = 1'b0;
      expected_events.push_back(ev);
   endfunction

   function automatic void match_order(logic [SEC_W-1:0] sec, logic buy,
                                       logic [QTY_W-1:0] qty_in, logic [IDENT_W-1:0] ident);
      int own;
      int opp;
      int slot;
      logic [QTY_W-1:0] qty;
      logic [QTY_W-1:0] rest;
      qty = qty_in;
      if (int'(sec) >= NUM_SECURITIES) return;
      own = 2 * int'(sec) + int'(buy);
      opp = 2 * int'(sec) + int'(!buy);
      if (qty == '0) begin
         add_event(EV_INCOMING_FILLED, ident, '0);
      end else begin
         while (qty != '0 && book_count[opp] != '0) begin
            slot = book_head[opp];
            rest = resting_qty[opp][slot];
            if (rest > qty) begin
               resting_qty[opp][slot] = rest - qty;
               add_event(EV_INCOMING_FILLED, ident, '0);
               qty = '0;
            end else begin
               if (rest == qty) begin
                  add_event(EV_INCOMING_FILLED, ident, '0);
                  qty = '0;
               end else begin
                  qty = qty - rest;
               end
               add_event(EV_RESTING_FILLED, resting_ident[opp][slot], '0);
               book_head[opp]  = wrap_slot(slot + 1);
               book_count[opp] = book_count[opp] - 1'b1;
            end
         end
         if (qty != '0) begin
            if (int'(book_count[own]) < FIFO_DEPTH) begin
               slot = wrap_slot(int'(book_head[own]) + int'(book_count[own]));
               resting_ident[own][slot] = ident;
               resting_qty[own][slot]   = qty;
               book_count[own]          = book_count[own] + 1'b1;
               add_event(EV_QUEUED, ident, qty);
            end else begin
               add_event(EV_DROPPED, ident, qty);
            end
         end
      end
      expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         for (int b = 0; b < NUM_BOOKS; b++) begin
            book_head[b]  = '0;
            book_count[b] = '0;
         end
         expected_events.delete();
         fail_count  = 0;
         order_count = 0;
         event_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            event_count++;
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d order %h left %0d", rsp.event_kind,
                      rsp.event_order, rsp.left_quantity);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, got %0d", want.event_kind, rsp.event_kind);
                  fail_count++;
               end
               if (rsp.event_order !== want.event_order) begin
                  $error("event_order: expected %h, got %h", want.event_order, rsp.event_order);
                  fail_count++;
               end
               if (rsp.left_quantity !== want.left_quantity) begin
                  $error("left_quantity: expected %0d, got %0d", want.left_quantity,
                         rsp.left_quantity);
                  fail_count++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp.last);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            order_count++;
            match_order(req.security_index, req.is_buy, req.quantity, req.order_ident);
         end
      end
      pending_count = expected_events.size();
   end

endmodule

@@ dv/tb_top.sv @@
// top of the market order fifo matcher testbench: clock, reset, order stimulus and verdict
// depends on mofm_pkg, both channel interfaces, the matcher and mofm_match_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mofm_pkg::*;

   localparam int NUM_SECURITIES = 8;
   localparam int FIFO_DEPTH     = 16;
   localparam logic [QTY_W-1:0] QTY_MAX = '1;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   fail_count;
   int   pending_count;
   int   order_count;
   int   event_count;
   logic [SEC_W-1:0] hot_sec;
   logic             hot_side;

   mofm_req_if req_bus ();
   mofm_rsp_if rsp_bus ();

   market_order_fifo_matcher #(
      .NUM_SECURITIES(NUM_SECURITIES),
      .FIFO_DEPTH    (FIFO_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   mofm_match_checker #(
      .NUM_SECURITIES(NUM_SECURITIES),
      .FIFO_DEPTH    (FIFO_DEPTH)
   ) match_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .order_count  (order_count),
      .event_count  (event_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_order(logic [SEC_W-1:0] sec, logic buy, logic [QTY_W-1:0] qty,
                             logic [IDENT_W-1:0] ident);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.security_index <= sec;
      req_bus.is_buy         <= buy;
      req_bus.quantity       <= qty;
      req_bus.order_ident    <= ident;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic random_orders(int n);
      logic [SEC_W-1:0] sec;
      logic             buy;
      logic [QTY_W-1:0] qty;
      int               pick;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 6) hot_sec = SEC_W'($urandom_range(NUM_SECURITIES - 1));
         if ($urandom_range(99) < 12) hot_side = ~hot_side;
         sec  = ($urandom_range(99) < 75) ? hot_sec : SEC_W'($urandom_range(7));
         buy  = ($urandom_range(99) < 70) ? hot_side : 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 3)
            qty = '0;
         else if (pick < 5)
            qty = QTY_MAX;
         else if (pick < 18)
            qty = QTY_W'($urandom);
         else
            qty = QTY_W'($urandom_range(1, 24));
         send_order(sec, buy, qty, $urandom);
      end
   endtask

   task automatic directed_orders();
      // zero quantity, then a max order rested, reduced and matched exactly
      send_order(SEC_W'(0), 1'b0, '0, 32'h0000_0000);
      send_order(SEC_W'(0), 1'b1, QTY_MAX, 32'hFFFF_FFFF);
      send_order(SEC_W'(0), 1'b0, QTY_W'(5), 32'h0000_0001);
      send_order(SEC_W'(0), 1'b0, QTY_W'(QTY_MAX - 5), 32'h0000_0002);
      send_order(SEC_W'(3), 1'b1, '0, 32'hA5A5_5A5A);
      // fill one book, overflow it, then sweep it whole
      for (int k = 0; k < FIFO_DEPTH; k++) begin
         send_order(SEC_W'(7), 1'b0, QTY_W'(k + 1), 32'h0000_0100 + k);
      end
      send_order(SEC_W'(7), 1'b0, QTY_W'(9), 32'h0000_0200);
      send_order(SEC_W'(7), 1'b1, QTY_W'(FIFO_DEPTH * (FIFO_DEPTH + 1) / 2 + 7),
                 32'h0000_0300);
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.security_index = '0;
      req_bus.is_buy         = 1'b0;
      req_bus.quantity       = '0;
      req_bus.order_ident    = '0;
      rsp_bus.ready          = 1'b0;
      send_idle_pct          = 8;
      recv_stall_pct         = 59;
      hot_sec                = '0;
      hot_side               = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      directed_orders();
      random_orders(40);
      wait_drained();

      send_idle_pct  = 59;
      recv_stall_pct = 8;
      random_orders(15);
      wait_drained();
      random_orders(15);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_orders(30);
      wait_drained();
      repeat (60) @(negedge clock);

      $display("tb_top: %0d orders sent and %0d events checked over directed and random items,",
               order_count, event_count);
      $display("tb_top: with idling on either side and a stretch with none");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
